@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the smoothing gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset gating.
`define VSSG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("vssg: same-cycle check failed");

// Next-cycle implication under reset gating.
`define VSSG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("vssg: next-cycle check failed");

`endif

@@ hw/rtl/vssg_pkg.sv @@
// Shared types, constants and register codes of the vital-sign smoothing gate.
package vssg_pkg;

	// History depth defaults
	localparam int SPO2_DEPTH_DEF = 8;
	localparam int RATE_DEPTH_DEF = 5;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Field widths
	localparam int SPO2_W     = 7;
	localparam int RATE_W     = 8;
	localparam int RAW_W      = 8;
	localparam int PERF_W     = 16;
	localparam int CONF_W     = 7;
	localparam int RUN_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Gate limits
	localparam logic [RAW_W-1:0] SPO2_TOP  = 8'd100;
	localparam logic [RAW_W-1:0] RATE_LOW  = 8'd30;
	localparam logic [RAW_W-1:0] RATE_HIGH = 8'd220;
	localparam logic [RUN_W-1:0] RUN_MAX   = 4'd15;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HR_FROM_PPG     = 3'd0,
		CFG_SPO2_JUMP_LIMIT = 3'd1,
		CFG_HR_JUMP_LIMIT   = 3'd2,
		CFG_SPO2_MIN_CONF   = 3'd3,
		CFG_HR_MIN_PERF     = 3'd4,
		CFG_LOSS_PERF       = 3'd5,
		CFG_LOSS_RUN_LEN    = 3'd6
	} cfg_idx_t;

	// Register reset values
	localparam logic               RST_HR_FROM_PPG     = 1'b0;
	localparam logic [RAW_W-1:0]   RST_SPO2_JUMP_LIMIT = 8'd5;
	localparam logic [RAW_W-1:0]   RST_HR_JUMP_LIMIT   = 8'd30;
	localparam logic [CONF_W-1:0]  RST_SPO2_MIN_CONF   = 7'd50;
	localparam logic [PERF_W-1:0]  RST_HR_MIN_PERF     = 16'd100;
	localparam logic [PERF_W-1:0]  RST_LOSS_PERF       = 16'd50;
	localparam logic [RUN_W-1:0]   RST_LOSS_RUN_LEN    = 4'd3;

	typedef struct packed {
		logic              hr_from_ppg;
		logic [RAW_W-1:0]  spo2_jump_limit;
		logic [RAW_W-1:0]  hr_jump_limit;
		logic [CONF_W-1:0] spo2_min_confidence;
		logic [PERF_W-1:0] hr_min_perfusion;
		logic [PERF_W-1:0] loss_perfusion;
		logic [RUN_W-1:0]  loss_run_length;
	} cfg_t;

	// Classified reading handed from front to back
	typedef struct packed {
		logic              low_run_hit;
		logic              spo2_gate;
		logic [SPO2_W-1:0] spo2_val;
		logic              rate_gate;
		logic [RATE_W-1:0] rate_val;
		logic              rate_pub;
	} cmd_t;

endpackage

@@ hw/rtl/vssg_if.sv @@
// Reading and result channel interfaces of the smoothing gate.
interface vssg_in_if;
	logic                          valid;
	logic                          ready;
	logic [vssg_pkg::RAW_W-1:0]    spo2_raw;
	logic                          spo2_ok;
	logic [vssg_pkg::RAW_W-1:0]    rate_raw;
	logic                          rate_ok;
	logic [vssg_pkg::PERF_W-1:0]   perfusion;
	logic [vssg_pkg::CONF_W-1:0]   confidence;

	modport source (output valid, spo2_raw, spo2_ok, rate_raw, rate_ok, perfusion,
		confidence, input ready);
	modport sink (input valid, spo2_raw, spo2_ok, rate_raw, rate_ok, perfusion,
		confidence, output ready);
endinterface

interface vssg_out_if;
	logic                          valid;
	logic                          ready;
	logic                          spo2_publish;
	logic [vssg_pkg::SPO2_W-1:0]   spo2_average;
	logic                          spo2_outlier;
	logic                          spo2_cleared;
	logic                          rate_publish;
	logic [vssg_pkg::RATE_W-1:0]   rate_average;
	logic                          rate_outlier;

	modport source (output valid, spo2_publish, spo2_average, spo2_outlier, spo2_cleared,
		rate_publish, rate_average, rate_outlier, input ready);
	modport sink (input valid, spo2_publish, spo2_average, spo2_outlier, spo2_cleared,
		rate_publish, rate_average, rate_outlier, output ready);
endinterface

@@ hw/rtl/vital_sign_smoothing_gate.sv @@
// Top level of the vital-sign smoothing gate: register file, front, queue and back.
//
//   channel   direction  beat contents
//   reading   in         spo2_raw, spo2_ok, rate_raw, rate_ok, perfusion, confidence
//   result    out        publish/average/outlier per vital, spo2_cleared
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// With no history written, a reading passes the back end through pop, update and load.
// A written history adds a restoring divide of one bit per cycle (11 steps for heart rate
// at depth 5, 10 for SpO2 at depth 8, run side by side) before the quotient is taken into
// the mean. The divide sets the rate.
// Reset empties both histories through their fill counts; no clearing pass is needed.
// A two-beat queue lets readings enter while the back end works or the result stalls.
module vital_sign_smoothing_gate #(
	parameter int SPO2_DEPTH = vssg_pkg::SPO2_DEPTH_DEF,
	parameter int RATE_DEPTH = vssg_pkg::RATE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vssg_in_if.sink                           reading,
	vssg_out_if.source                        result,
	input  logic                              cfg_we,
	input  logic [vssg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vssg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	vssg_pkg::cfg_t cfg_q;
	vssg_pkg::cmd_t push_cmd;
	vssg_pkg::cmd_t q_head;
	logic           push;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				hr_from_ppg:         vssg_pkg::RST_HR_FROM_PPG,
				spo2_jump_limit:     vssg_pkg::RST_SPO2_JUMP_LIMIT,
				hr_jump_limit:       vssg_pkg::RST_HR_JUMP_LIMIT,
				spo2_min_confidence: vssg_pkg::RST_SPO2_MIN_CONF,
				hr_min_perfusion:    vssg_pkg::RST_HR_MIN_PERF,
				loss_perfusion:      vssg_pkg::RST_LOSS_PERF,
				loss_run_length:     vssg_pkg::RST_LOSS_RUN_LEN
			};
		end else if (cfg_we) begin
			unique case (cfg_index)
				vssg_pkg::CFG_HR_FROM_PPG:
					cfg_q.hr_from_ppg <= cfg_data[0];
				vssg_pkg::CFG_SPO2_JUMP_LIMIT:
					cfg_q.spo2_jump_limit <= cfg_data[vssg_pkg::RAW_W-1:0];
				vssg_pkg::CFG_HR_JUMP_LIMIT:
					cfg_q.hr_jump_limit <= cfg_data[vssg_pkg::RAW_W-1:0];
				vssg_pkg::CFG_SPO2_MIN_CONF:
					cfg_q.spo2_min_confidence <= cfg_data[vssg_pkg::CONF_W-1:0];
				vssg_pkg::CFG_HR_MIN_PERF:
					cfg_q.hr_min_perfusion <= cfg_data[vssg_pkg::PERF_W-1:0];
				vssg_pkg::CFG_LOSS_PERF:
					cfg_q.loss_perfusion <= cfg_data[vssg_pkg::PERF_W-1:0];
				vssg_pkg::CFG_LOSS_RUN_LEN:
					cfg_q.loss_run_length <= cfg_data[vssg_pkg::RUN_W-1:0];
				default: ;
			endcase
		end
	end

	vssg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.reading(reading),
		.push   (push),
		.cmd    (push_cmd),
		.full   (q_full)
	);

	vssg_queue #(.DEPTH(vssg_pkg::QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	vssg_back #(.SPO2_DEPTH(SPO2_DEPTH), .RATE_DEPTH(RATE_DEPTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_head (q_head),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.result (result)
	);
endmodule

@@ hw/rtl/vssg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module vssg_div #(
	parameter int NUM_W = 11,
	parameter int DEN_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_diff;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;
	logic [NUM_W-1:0] quo_nx;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		rem_sh   = {rem_q, quo_q[NUM_W-1]};
		rem_diff = rem_sh - {1'b0, den_q};
		ge       = rem_sh >= {1'b0, den_q};
		rem_nx   = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		quo_nx   = {quo_q[NUM_W-2:0], ge};
	end

	// Count steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then advance the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ hw/rtl/vssg_queue.sv @@
// Short queue of classified readings between front and back.
module vssg_queue #(
	parameter int DEPTH = vssg_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vssg_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output vssg_pkg::cmd_t  head,
	output logic            empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vssg_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end
endmodule

@@ hw/rtl/vssg_front.sv @@
// Front end: accepts readings, applies the quality gates and tracks contact loss.
module vssg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  vssg_pkg::cfg_t  cfg,
	vssg_in_if.sink         reading,
	output logic            push,
	output vssg_pkg::cmd_t  cmd,
	input  logic            full
);
	logic [vssg_pkg::RUN_W-1:0] run_q;
	logic [vssg_pkg::RUN_W-1:0] run_inc;
	logic                       low;
	logic                       hit;

	assign reading.ready = !full;
	assign push          = reading.valid && !full;

	// Count low-perfusion readings, saturating
	always_comb begin
		low     = reading.perfusion < cfg.loss_perfusion;
		run_inc = (run_q == vssg_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
		hit     = low && (run_inc >= cfg.loss_run_length);
	end

	// Classify the reading
	always_comb begin
		cmd.low_run_hit = hit;
		cmd.spo2_gate   = reading.spo2_ok && (reading.spo2_raw != '0)
			&& (reading.spo2_raw <= vssg_pkg::SPO2_TOP)
			&& (reading.confidence >= cfg.spo2_min_confidence);
		cmd.spo2_val    = reading.spo2_raw[vssg_pkg::SPO2_W-1:0];
		cmd.rate_gate   = reading.rate_ok && (reading.rate_raw > vssg_pkg::RATE_LOW)
			&& (reading.rate_raw < vssg_pkg::RATE_HIGH)
			&& (reading.perfusion >= cfg.hr_min_perfusion);
		cmd.rate_val    = reading.rate_raw;
		cmd.rate_pub    = cmd.rate_gate && cfg.hr_from_ppg;
	end

	// Restart the run on a hit or on good contact
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			run_q <= '0;
		else if (push)
			run_q <= (low && !hit) ? run_inc : '0;
	end
endmodule

@@ hw/rtl/vssg_back.sv @@
// Back end: outlier test, ring histories, mean dividers and the result register.
module vssg_back #(
	parameter int SPO2_DEPTH = vssg_pkg::SPO2_DEPTH_DEF,
	parameter int RATE_DEPTH = vssg_pkg::RATE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vssg_pkg::cfg_t  cfg,
	input  vssg_pkg::cmd_t  q_head,
	input  logic            q_empty,
	output logic            q_pop,
	vssg_out_if.source      result
);
	localparam int SW     = vssg_pkg::SPO2_W;
	localparam int RW     = vssg_pkg::RATE_W;
	localparam int S_SLOT_W = (SPO2_DEPTH > 1) ? $clog2(SPO2_DEPTH) : 1;
	localparam int S_FILL_W = $clog2(SPO2_DEPTH + 1);
	localparam int S_SUM_W  = SW + S_SLOT_W;
	localparam int R_SLOT_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
	localparam int R_FILL_W = $clog2(RATE_DEPTH + 1);
	localparam int R_SUM_W  = RW + R_SLOT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t         state_q;
	vssg_pkg::cmd_t cmd_q;

	// SpO2 history
	logic [SW-1:0]       s_ring_q [SPO2_DEPTH];
	logic [S_SLOT_W-1:0] s_slot_q;
	logic [S_FILL_W-1:0] s_fill_q;
	logic [S_SUM_W-1:0]  s_sum_q;
	logic [SW-1:0]       s_mean_q;
	logic                s_pend_q;
	logic                s_out_q;
	logic                s_clr_q;

	// Heart-rate history
	logic [RW-1:0]       r_ring_q [RATE_DEPTH];
	logic [R_SLOT_W-1:0] r_slot_q;
	logic [R_FILL_W-1:0] r_fill_q;
	logic [R_SUM_W-1:0]  r_sum_q;
	logic [RW-1:0]       r_mean_q;
	logic                r_pend_q;
	logic                r_out_q;

	logic                out_valid_q;
	logic                load;

	// SpO2 update terms
	logic                s_clr;
	logic [S_SLOT_W-1:0] s_slot_e;
	logic [S_FILL_W-1:0] s_fill_e;
	logic [S_SUM_W-1:0]  s_sum_e;
	logic [SW-1:0]       s_mean_e;
	logic [SW-1:0]       s_diff;
	logic                s_jump;
	logic                s_wr;
	logic                s_full;
	logic [S_SUM_W-1:0]  s_sum_n;
	logic [S_FILL_W-1:0] s_fill_n;
	logic [S_SLOT_W-1:0] s_slot_n;
	logic                s_done;
	logic [S_SUM_W-1:0]  s_quo;

	// Heart-rate update terms
	logic [RW-1:0]       r_diff;
	logic                r_jump;
	logic                r_wr;
	logic                r_full;
	logic [R_SUM_W-1:0]  r_sum_n;
	logic [R_FILL_W-1:0] r_fill_n;
	logic [R_SLOT_W-1:0] r_slot_n;
	logic                r_done;
	logic [R_SUM_W-1:0]  r_quo;

	// Drop the SpO2 history on a contact-loss run, then test and insert
	always_comb begin
		s_clr    = cmd_q.low_run_hit && (s_fill_q != '0);
		s_slot_e = s_clr ? '0 : s_slot_q;
		s_fill_e = s_clr ? '0 : s_fill_q;
		s_sum_e  = s_clr ? '0 : s_sum_q;
		s_mean_e = s_clr ? '0 : s_mean_q;
		s_diff   = (cmd_q.spo2_val > s_mean_e) ? cmd_q.spo2_val - s_mean_e
			: s_mean_e - cmd_q.spo2_val;
		s_jump   = cmd_q.spo2_gate && (s_fill_e != '0) && (s_mean_e != '0)
			&& ({1'b0, s_diff} > cfg.spo2_jump_limit);
		s_wr     = cmd_q.spo2_gate && !s_jump;
		s_full   = s_fill_e == S_FILL_W'(SPO2_DEPTH);
		s_sum_n  = s_sum_e + S_SUM_W'(cmd_q.spo2_val)
			- (s_full ? S_SUM_W'(s_ring_q[s_slot_e]) : '0);
		s_fill_n = s_full ? s_fill_e : s_fill_e + 1'b1;
		s_slot_n = (s_slot_e == S_SLOT_W'(SPO2_DEPTH - 1)) ? '0 : s_slot_e + 1'b1;
	end

	// Test and insert the heart rate
	always_comb begin
		r_diff   = (cmd_q.rate_val > r_mean_q) ? cmd_q.rate_val - r_mean_q
			: r_mean_q - cmd_q.rate_val;
		r_jump   = cmd_q.rate_gate && (r_fill_q != '0) && (r_mean_q != '0)
			&& (r_diff > cfg.hr_jump_limit);
		r_wr     = cmd_q.rate_gate && !r_jump;
		r_full   = r_fill_q == R_FILL_W'(RATE_DEPTH);
		r_sum_n  = r_sum_q + R_SUM_W'(cmd_q.rate_val)
			- (r_full ? R_SUM_W'(r_ring_q[r_slot_q]) : '0);
		r_fill_n = r_full ? r_fill_q : r_fill_q + 1'b1;
		r_slot_n = (r_slot_q == R_SLOT_W'(RATE_DEPTH - 1)) ? '0 : r_slot_q + 1'b1;
	end

	// Mean dividers, started from the update cycle
	vssg_div #(.NUM_W(S_SUM_W), .DEN_W(S_FILL_W)) u_spo2_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_UPD && s_wr),
		.num   (s_sum_n),
		.den   (s_fill_n),
		.done  (s_done),
		.quo   (s_quo)
	);

	vssg_div #(.NUM_W(R_SUM_W), .DEN_W(R_FILL_W)) u_rate_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_UPD && r_wr),
		.num   (r_sum_n),
		.den   (r_fill_n),
		.done  (r_done),
		.quo   (r_quo)
	);

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load  = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	// Sequence one reading and hold the history counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s_slot_q    <= '0;
			s_fill_q    <= '0;
			s_sum_q     <= '0;
			s_mean_q    <= '0;
			s_pend_q    <= 1'b0;
			r_slot_q    <= '0;
			r_fill_q    <= '0;
			r_sum_q     <= '0;
			r_mean_q    <= '0;
			r_pend_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					s_slot_q <= s_wr ? s_slot_n : s_slot_e;
					s_fill_q <= s_wr ? s_fill_n : s_fill_e;
					s_sum_q  <= s_wr ? s_sum_n : s_sum_e;
					s_mean_q <= s_mean_e;
					s_pend_q <= s_wr;
					if (r_wr) begin
						r_slot_q <= r_slot_n;
						r_fill_q <= r_fill_n;
						r_sum_q  <= r_sum_n;
					end
					r_pend_q <= r_wr;
					state_q  <= (s_wr || r_wr) ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (s_done) begin
						s_mean_q <= s_quo[SW-1:0];
						s_pend_q <= 1'b0;
					end
					if (r_done) begin
						r_mean_q <= r_quo[RW-1:0];
						r_pend_q <= 1'b0;
					end
					if ((!s_pend_q || s_done) && (!r_pend_q || r_done))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Latch the command, write the rings, fill the result beat
	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_head;
		if (state_q == ST_UPD) begin
			if (s_wr)
				s_ring_q[s_slot_e] <= cmd_q.spo2_val;
			if (r_wr)
				r_ring_q[r_slot_q] <= cmd_q.rate_val;
			s_out_q <= s_jump;
			s_clr_q <= s_clr;
			r_out_q <= r_jump;
		end
		if (load) begin
			result.spo2_publish <= cmd_q.spo2_gate;
			result.spo2_average <= s_mean_q;
			result.spo2_outlier <= s_out_q;
			result.spo2_cleared <= s_clr_q;
			result.rate_publish <= cmd_q.rate_pub;
			result.rate_average <= r_mean_q;
			result.rate_outlier <= r_out_q;
		end
	end

	assign result.valid = out_valid_q;
endmodule

@@ hw/rtl/vssg_checker.sv @@
// Port-level checker of the smoothing gate and its bind to the top level.
`include "assert_macros.svh"

module vssg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          spo2_publish,
	input logic [vssg_pkg::SPO2_W-1:0]   spo2_average,
	input logic                          spo2_outlier,
	input logic                          spo2_cleared,
	input logic                          rate_publish,
	input logic [vssg_pkg::RATE_W-1:0]   rate_average,
	input logic                          rate_outlier
);
	logic [2:0] outstanding_q;
	logic [vssg_pkg::SPO2_W+vssg_pkg::RATE_W+4:0] out_word;

	assign out_word = {spo2_publish, spo2_average, spo2_outlier, spo2_cleared,
		rate_publish, rate_average, rate_outlier};

	// Track readings taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if ((in_valid && in_ready) && !(out_valid && out_ready))
			outstanding_q <= outstanding_q + 1'b1;
		else if (!(in_valid && in_ready) && (out_valid && out_ready))
			outstanding_q <= outstanding_q - 1'b1;
	end

	`VSSG_ASSERT_NXT(a_result_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))
	`VSSG_ASSERT_IMP(a_no_extra_beat, clk, arst_n, out_valid, outstanding_q != 3'd0)
	`VSSG_ASSERT_IMP(a_clear_no_jump, clk, arst_n, out_valid && spo2_cleared, !spo2_outlier)
	`VSSG_ASSERT_IMP(a_jump_gated, clk, arst_n, out_valid && spo2_outlier, spo2_publish)
	`VSSG_ASSERT_IMP(a_spo2_range, clk, arst_n, out_valid, spo2_average <= 7'd100)
endmodule

bind vital_sign_smoothing_gate vssg_checker u_vssg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (reading.valid),
	.in_ready    (reading.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.spo2_publish(result.spo2_publish),
	.spo2_average(result.spo2_average),
	.spo2_outlier(result.spo2_outlier),
	.spo2_cleared(result.spo2_cleared),
	.rate_publish(result.rate_publish),
	.rate_average(result.rate_average),
	.rate_outlier(result.rate_outlier)
);

@@ dv/vital_sign_smoothing_gate_tb.sv @@
// Self-checking testbench of the vital-sign smoothing gate: directed and random readings.
module vital_sign_smoothing_gate_tb;

	localparam int SPO2_DEPTH   = vssg_pkg::SPO2_DEPTH_DEF;
	localparam int RATE_DEPTH   = vssg_pkg::RATE_DEPTH_DEF;
	localparam int VITAL_SPO2   = 0;
	localparam int VITAL_RATE   = 1;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 78;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [vssg_pkg::RAW_W-1:0]  spo2_raw;
		logic                        spo2_ok;
		logic [vssg_pkg::RAW_W-1:0]  rate_raw;
		logic                        rate_ok;
		logic [vssg_pkg::PERF_W-1:0] perfusion;
		logic [vssg_pkg::CONF_W-1:0] confidence;
	} reading_t;

	typedef struct packed {
		logic                        spo2_publish;
		logic [vssg_pkg::SPO2_W-1:0] spo2_average;
		logic                        spo2_outlier;
		logic                        spo2_cleared;
		logic                        rate_publish;
		logic [vssg_pkg::RATE_W-1:0] rate_average;
		logic                        rate_outlier;
	} smoothed_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            rd_valid  = 1'b0;
	reading_t                        rd_beat   = '0;
	logic                            res_ready = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [vssg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [vssg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	vssg_in_if  reading_ch ();
	vssg_out_if result_ch ();

	assign reading_ch.valid      = rd_valid;
	assign reading_ch.spo2_raw   = rd_beat.spo2_raw;
	assign reading_ch.spo2_ok    = rd_beat.spo2_ok;
	assign reading_ch.rate_raw   = rd_beat.rate_raw;
	assign reading_ch.rate_ok    = rd_beat.rate_ok;
	assign reading_ch.perfusion  = rd_beat.perfusion;
	assign reading_ch.confidence = rd_beat.confidence;
	assign result_ch.ready       = res_ready;

	vital_sign_smoothing_gate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.reading   (reading_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted state of the gate
	vssg_pkg::cfg_t              settings;
	logic [vssg_pkg::RATE_W-1:0] hist_ring [2][16];
	int                          hist_slot [2];
	int                          hist_fill [2];
	int                          hist_mean [2];
	int                          low_run;

	// Stimulus and scoreboard bookkeeping
	reading_t  pending_readings [$];
	smoothed_t expected_results [$];
	smoothed_t observed;
	smoothed_t predicted;
	int        items_queued = 0;
	int        results_seen = 0;
	int        mismatches   = 0;
	int        gap_pct      = 10;
	int        stall_pct    = 10;
	int        gap_left     = 0;
	int        stall_left   = 0;
	int        quiet_cycles = 0;
	int        spo2_base    = 96;
	int        rate_base    = 75;
	int        low_burst    = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// Uniform offset in [-w, w]
	function automatic int spread(int w);
		return int'($urandom_range(0, 2 * w)) - w;
	endfunction

	// Offer a gated value to one history; return 1 when rejected as a jump
	function automatic bit hist_offer(int v, int value, int limit);
		int delta;
		int sum;
		int depth;
		depth = (v == VITAL_SPO2) ? SPO2_DEPTH : RATE_DEPTH;
		if (hist_fill[v] > 0 && hist_mean[v] > 0) begin
			delta = (value > hist_mean[v]) ? value - hist_mean[v] : hist_mean[v] - value;
			if (delta > limit)
				return 1'b1;
		end
		hist_ring[v][hist_slot[v]] = 8'(value);
		hist_slot[v] = (hist_slot[v] + 1) % depth;
		if (hist_fill[v] < depth)
			hist_fill[v]++;
		sum = 0;
		for (int i = 0; i < hist_fill[v]; i++)
			sum += int'(hist_ring[v][i]);
		hist_mean[v] = sum / hist_fill[v];
		return 1'b0;
	endfunction

	// Advance the predicted state by one reading and queue the expected result
	function automatic void smooth_reading(reading_t r);
		smoothed_t e;
		e = '0;
		// count low-perfusion readings; a long enough run empties the SpO2 history
		if (r.perfusion < settings.loss_perfusion) begin
			if (low_run < int'(vssg_pkg::RUN_MAX))
				low_run++;
			if (low_run >= int'(settings.loss_run_length)) begin
				if (hist_fill[VITAL_SPO2] > 0) begin
					hist_fill[VITAL_SPO2] = 0;
					hist_slot[VITAL_SPO2] = 0;
					hist_mean[VITAL_SPO2] = 0;
					e.spo2_cleared = 1'b1;
				end
				low_run = 0;
			end
		end else begin
			low_run = 0;
		end
		if (r.spo2_ok && r.spo2_raw > 0 && r.spo2_raw <= vssg_pkg::SPO2_TOP &&
				r.confidence >= settings.spo2_min_confidence) begin
			e.spo2_publish = 1'b1;
			e.spo2_outlier = hist_offer(VITAL_SPO2, int'(r.spo2_raw),
				int'(settings.spo2_jump_limit));
		end
		if (r.rate_ok && r.rate_raw > vssg_pkg::RATE_LOW && r.rate_raw < vssg_pkg::RATE_HIGH &&
				r.perfusion >= settings.hr_min_perfusion) begin
			e.rate_outlier = hist_offer(VITAL_RATE, int'(r.rate_raw),
				int'(settings.hr_jump_limit));
			e.rate_publish = settings.hr_from_ppg;
		end
		e.spo2_average = 7'(hist_mean[VITAL_SPO2]);
		e.rate_average = 8'(hist_mean[VITAL_RATE]);
		expected_results.push_back(e);
	endfunction

	function automatic reading_t make_reading(int spo2, bit sok, int rate, bit rok, int perf,
			int conf);
		reading_t r;
		r.spo2_raw   = 8'(spo2);
		r.spo2_ok    = sok;
		r.rate_raw   = 8'(rate);
		r.rate_ok    = rok;
		r.perfusion  = 16'(perf);
		r.confidence = 7'(conf);
		return r;
	endfunction

	// Mostly plausible readings around the current averages, with jumps, dropouts and noise
	function automatic reading_t random_reading();
		reading_t r;
		int kind;
		int center;
		int w;
		int lo;
		kind = $urandom_range(0, 39);
		if (kind == 0 && low_burst == 0)
			low_burst = $urandom_range(1, 16);
		if (kind == 1 || kind == 2) begin
			r.spo2_raw   = 8'($urandom);
			r.spo2_ok    = 1'($urandom);
			r.rate_raw   = 8'($urandom);
			r.rate_ok    = 1'($urandom);
			r.perfusion  = 16'($urandom);
			r.confidence = 7'($urandom);
			return r;
		end
		// drift the nominal vitals, with an occasional step change
		spo2_base = clamp(spo2_base + spread(1), 70, 100);
		rate_base = clamp(rate_base + spread(3), 35, 215);
		if ($urandom_range(0, 49) == 0)
			spo2_base = $urandom_range(60, 100);
		if ($urandom_range(0, 49) == 0)
			rate_base = $urandom_range(35, 215);

		center = spo2_base;
		if (hist_fill[VITAL_SPO2] > 0 && hist_mean[VITAL_SPO2] > 0 && $urandom_range(0, 3) != 0)
			center = hist_mean[VITAL_SPO2];
		w = $urandom_range(0, settings.spo2_jump_limit + 1);
		if ($urandom_range(0, 7) == 0)
			w += 25;
		r.spo2_raw = 8'(clamp(center + spread(clamp(w, 0, 120)), 0, 105));
		r.spo2_ok  = ($urandom_range(0, 15) != 0);

		center = rate_base;
		if (hist_fill[VITAL_RATE] > 0 && $urandom_range(0, 3) != 0)
			center = hist_mean[VITAL_RATE];
		w = $urandom_range(0, settings.hr_jump_limit + 1);
		if ($urandom_range(0, 7) == 0)
			w += 60;
		r.rate_raw = 8'(clamp(center + spread(clamp(w, 0, 150)), 25, 225));
		r.rate_ok  = ($urandom_range(0, 15) != 0);

		if ($urandom_range(0, 9) == 0)
			r.confidence = 7'($urandom_range(0, 127));
		else if (settings.spo2_min_confidence <= 100)
			r.confidence = 7'($urandom_range(settings.spo2_min_confidence, 100));
		else
			r.confidence = 7'($urandom_range(settings.spo2_min_confidence, 127));

		if (low_burst > 0) begin
			low_burst--;
			r.perfusion = (settings.loss_perfusion > 0) ?
				16'($urandom_range(0, settings.loss_perfusion - 1)) : '0;
		end else begin
			lo = (settings.hr_min_perfusion > settings.loss_perfusion) ?
				int'(settings.hr_min_perfusion) : int'(settings.loss_perfusion);
			if ($urandom_range(0, 7) == 0)
				lo = int'(settings.loss_perfusion);
			r.perfusion = ($urandom_range(0, 3) == 0) ? 16'(lo) : 16'($urandom_range(lo, 65535));
		end
		return r;
	endfunction

	task automatic queue_reading(input reading_t r);
		pending_readings.push_back(r);
		items_queued++;
	endtask

	task automatic wait_until_drained();
		while (results_seen < items_queued)
			@(posedge clk);
	endtask

	task automatic write_register(input vssg_pkg::cfg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[vssg_pkg::CFG_DATA_W-1:0];
		case (idx)
			vssg_pkg::CFG_HR_FROM_PPG:     settings.hr_from_ppg         = value[0];
			vssg_pkg::CFG_SPO2_JUMP_LIMIT: settings.spo2_jump_limit     = 8'(value);
			vssg_pkg::CFG_HR_JUMP_LIMIT:   settings.hr_jump_limit       = 8'(value);
			vssg_pkg::CFG_SPO2_MIN_CONF:   settings.spo2_min_confidence = 7'(value);
			vssg_pkg::CFG_HR_MIN_PERF:     settings.hr_min_perfusion    = 16'(value);
			vssg_pkg::CFG_LOSS_PERF:       settings.loss_perfusion      = 16'(value);
			vssg_pkg::CFG_LOSS_RUN_LEN:    settings.loss_run_length     = 4'(value);
			default: ;
		endcase
	endtask

	// Pick the register set of one phase and write all of it
	task automatic apply_settings(input int phase);
		vssg_pkg::cfg_t s;
		case (phase)
			0: s = {1'b1, vssg_pkg::RST_SPO2_JUMP_LIMIT, vssg_pkg::RST_HR_JUMP_LIMIT,
				vssg_pkg::RST_SPO2_MIN_CONF, vssg_pkg::RST_HR_MIN_PERF,
				vssg_pkg::RST_LOSS_PERF, vssg_pkg::RST_LOSS_RUN_LEN};
			1: s = '0;
			2: s = {1'b1, 8'd2, 8'd8, 7'd90, 16'd150, 16'd300, 4'd0};
			3: s = '1;
			default: begin
				s.hr_from_ppg         = 1'($urandom_range(0, 1));
				s.spo2_jump_limit     = 8'(($urandom_range(0, 2) == 0) ?
					$urandom_range(0, 255) : $urandom_range(0, 12));
				s.hr_jump_limit       = 8'(($urandom_range(0, 2) == 0) ?
					$urandom_range(0, 255) : $urandom_range(0, 40));
				s.spo2_min_confidence = 7'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 127) : $urandom_range(0, 80));
				s.hr_min_perfusion    = 16'($urandom_range(0, 3000));
				s.loss_perfusion      = 16'($urandom_range(0, 800));
				s.loss_run_length     = 4'($urandom_range(0, 15));
			end
		endcase
		write_register(vssg_pkg::CFG_HR_FROM_PPG, int'(s.hr_from_ppg));
		write_register(vssg_pkg::CFG_SPO2_JUMP_LIMIT, int'(s.spo2_jump_limit));
		write_register(vssg_pkg::CFG_HR_JUMP_LIMIT, int'(s.hr_jump_limit));
		write_register(vssg_pkg::CFG_SPO2_MIN_CONF, int'(s.spo2_min_confidence));
		write_register(vssg_pkg::CFG_HR_MIN_PERF, int'(s.hr_min_perfusion));
		write_register(vssg_pkg::CFG_LOSS_PERF, int'(s.loss_perfusion));
		write_register(vssg_pkg::CFG_LOSS_RUN_LEN, int'(s.loss_run_length));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drive reading beats from the pending queue, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (rd_valid && reading_ch.ready)
				smooth_reading(rd_beat);
			if (!rd_valid || reading_ch.ready) begin
				if (gap_left == 0 && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
					gap_left = $urandom_range(1, 15);
				if (gap_left > 0) begin
					rd_valid <= 1'b0;
					gap_left--;
				end else if (pending_readings.size() > 0) begin
					rd_beat  <= pending_readings.pop_front();
					rd_valid <= 1'b1;
				end else begin
					rd_valid <= 1'b0;
				end
			end
		end
	end

	// Check each result beat against the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && res_ready) begin
				observed = {result_ch.spo2_publish, result_ch.spo2_average,
					result_ch.spo2_outlier, result_ch.spo2_cleared, result_ch.rate_publish,
					result_ch.rate_average, result_ch.rate_outlier};
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d arrived with no reading pending", results_seen);
				end else begin
					predicted = expected_results.pop_front();
					if (observed !== predicted) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"result %0d mismatch: spo2 pub/avg/out/clr exp %b/%0d/%b/%b",
								" got %b/%0d/%b/%b, rate pub/avg/out exp %b/%0d/%b got %b/%0d/%b"},
								results_seen,
								predicted.spo2_publish, predicted.spo2_average,
								predicted.spo2_outlier, predicted.spo2_cleared,
								observed.spo2_publish, observed.spo2_average,
								observed.spo2_outlier, observed.spo2_cleared,
								predicted.rate_publish, predicted.rate_average,
								predicted.rate_outlier,
								observed.rate_publish, observed.rate_average,
								observed.rate_outlier);
					end
				end
			end
			if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 15);
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Abort when no beat moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (rd_valid && reading_ch.ready) || (result_ch.valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("vital_sign_smoothing_gate_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int n;
		settings = {vssg_pkg::RST_HR_FROM_PPG, vssg_pkg::RST_SPO2_JUMP_LIMIT,
			vssg_pkg::RST_HR_JUMP_LIMIT, vssg_pkg::RST_SPO2_MIN_CONF,
			vssg_pkg::RST_HR_MIN_PERF, vssg_pkg::RST_LOSS_PERF, vssg_pkg::RST_LOSS_RUN_LEN};
		for (int v = 0; v < 2; v++) begin
			hist_slot[v] = 0;
			hist_fill[v] = 0;
			hist_mean[v] = 0;
			for (int i = 0; i < 16; i++)
				hist_ring[v][i] = '0;
		end
		low_run = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed readings under reset settings: field extremes and gate edges
		queue_reading(make_reading(0, 1, 0, 1, 0, 0));
		queue_reading(make_reading(255, 1, 255, 1, 65535, 127));
		queue_reading(make_reading(101, 1, 220, 1, 1000, 100));
		queue_reading(make_reading(100, 1, 219, 1, 1000, 100));
		// smallest in-range values jump far from the first averages
		queue_reading(make_reading(1, 1, 31, 1, 1000, 100));
		queue_reading(make_reading(98, 0, 80, 0, 1000, 100));
		queue_reading(make_reading(97, 1, 30, 1, 1000, 49));
		queue_reading(make_reading(97, 1, 120, 1, 99, 50));
		queue_reading(make_reading(95, 1, 200, 1, 100, 60));
		// fill both histories past their depth so the slots wrap
		queue_reading(make_reading(96, 1, 190, 1, 5000, 100));
		queue_reading(make_reading(97, 1, 205, 1, 5000, 100));
		queue_reading(make_reading(98, 1, 210, 1, 5000, 100));
		queue_reading(make_reading(99, 1, 198, 1, 5000, 100));
		queue_reading(make_reading(97, 1, 202, 1, 5000, 100));
		queue_reading(make_reading(96, 1, 195, 1, 5000, 100));
		// probe contact lost for a full run: SpO2 history cleared
		queue_reading(make_reading(96, 1, 150, 1, 49, 80));
		queue_reading(make_reading(96, 1, 150, 1, 0, 80));
		queue_reading(make_reading(96, 1, 150, 1, 10, 80));
		// a good reading breaks a run
		queue_reading(make_reading(0, 0, 150, 1, 49, 80));
		queue_reading(make_reading(0, 0, 150, 1, 60, 80));
		queue_reading(make_reading(0, 0, 150, 1, 1, 80));
		queue_reading(make_reading(0, 0, 0, 0, 2, 0));
		queue_reading(make_reading(0, 0, 0, 0, 3, 0));
		// the same run again finds the history already empty
		queue_reading(make_reading(0, 0, 0, 0, 4, 0));
		queue_reading(make_reading(0, 0, 0, 0, 5, 0));
		queue_reading(make_reading(0, 0, 0, 0, 6, 0));

		// Random phases, each under its own register set
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_until_drained();
			apply_settings(p);
			if (p == 5 || p == NUM_PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				@(posedge clk);
				if (pending_readings.size() < 2) begin
					queue_reading(random_reading());
					n++;
				end
			end
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("vital_sign_smoothing_gate_tb passed");
		else
			$display("vital_sign_smoothing_gate_tb failed");
		$finish;
	end

endmodule

@@ vital_sign_smoothing_gate.f @@
+incdir+hw/rtl
hw/rtl/vssg_pkg.sv
hw/rtl/vssg_if.sv
hw/rtl/vssg_div.sv
hw/rtl/vssg_queue.sv
hw/rtl/vssg_front.sv
hw/rtl/vssg_back.sv
hw/rtl/vital_sign_smoothing_gate.sv
hw/rtl/vssg_checker.sv
dv/vital_sign_smoothing_gate_tb.sv
